[hw/rtl/cms_pkg.sv]
// Package with the types, constants and helpers of the conditional marker stripper.
`timescale 1ns / 1ps

package cms_pkg;

    localparam int BYTE_W      = 8;
    localparam int PATTERN_MAX = 7;
    localparam int PAT_W       = BYTE_W * PATTERN_MAX;
    localparam int LEN_W       = 3;
    localparam int MAX_RESULTS = 11;
    localparam int POS_W       = 4;

    localparam logic [BYTE_W-1:0] CHR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHR_OPEN  = 8'h28;
    localparam logic [BYTE_W-1:0] CHR_CLOSE = 8'h29;

    localparam logic REG_PATTERN_BYTES  = 1'b0;
    localparam logic REG_PATTERN_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_SPACE   = 3'd1,
        PH_OPEN1   = 3'd2,
        PH_PATTERN = 3'd3,
        PH_MATCHED = 3'd4,
        PH_CLOSE1  = 3'd5
    } cms_phase_t;

    typedef enum logic {
        RP_IDLE = 1'b0,
        RP_RUN  = 1'b1
    } cms_rp_state_t;

    // One replay job: head bytes, pattern prefix, optional close paren, then the data byte.
    typedef struct packed {
        logic              emit;
        logic [1:0]        head;
        logic [LEN_W-1:0]  pat_n;
        logic              close;
        logic [BYTE_W-1:0] data;
    } cms_job_t;

    function automatic logic [BYTE_W-1:0] pat_byte(input logic [PAT_W-1:0] bytes,
                                                   input logic [LEN_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        b = '0;
        if (int'(idx) < PATTERN_MAX) begin
            b = bytes[idx*BYTE_W +: BYTE_W];
        end
        return b;
    endfunction

endpackage

[hw/rtl/cms_matcher.sv]
// Marker recognizer: match phase, matched count and the shared byte comparator.
`timescale 1ns / 1ps

module cms_matcher
    import cms_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    accept,
    input  logic [BYTE_W-1:0]       in_byte,
    input  logic [PAT_W-1:0]        pattern_bytes,
    input  logic [LEN_W-1:0]        pattern_length,
    output cms_job_t                job
);

    cms_phase_t        phase_reg, phase_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] expect_byte;
    logic              hit;
    logic [LEN_W:0]    count_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            count_reg <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_comb begin
        case (phase_reg)
            PH_SPACE, PH_OPEN1: expect_byte = CHR_OPEN;
            PH_PATTERN:         expect_byte = pat_byte(pattern_bytes, count_reg);
            PH_MATCHED,
            PH_CLOSE1:          expect_byte = CHR_CLOSE;
            default:            expect_byte = CHR_SPACE;
        endcase
        hit       = (in_byte == expect_byte);
        count_inc = {1'b0, count_reg} + 1'b1;
    end

    always_comb begin
        phase_next = PH_START;
        count_next = count_reg;
        job.emit   = 1'b1;
        job.head   = 2'd3;
        job.pat_n  = pattern_length;
        job.close  = 1'b0;
        job.data   = in_byte;
        case (phase_reg)
            PH_SPACE: begin
                job.head  = 2'd1;
                job.pat_n = '0;
                if (hit) begin
                    job.emit   = 1'b0;
                    phase_next = PH_OPEN1;
                end
            end
            PH_OPEN1: begin
                job.head  = 2'd2;
                job.pat_n = '0;
                if (hit) begin
                    job.emit   = 1'b0;
                    count_next = '0;
                    phase_next = (pattern_length == '0) ? PH_MATCHED : PH_PATTERN;
                end
            end
            PH_PATTERN: begin
                job.pat_n = count_reg;
                if (hit && int'(count_reg) < PATTERN_MAX) begin
                    job.emit   = 1'b0;
                    count_next = count_inc[LEN_W-1:0];
                    phase_next = (count_inc >= {1'b0, pattern_length}) ? PH_MATCHED
                                                                        : PH_PATTERN;
                end
            end
            PH_MATCHED: begin
                if (hit) begin
                    job.emit   = 1'b0;
                    phase_next = PH_CLOSE1;
                end
            end
            PH_CLOSE1: begin
                job.close = 1'b1;
                if (hit) begin
                    job.emit = 1'b0;
                end
            end
            default: begin
                job.head  = 2'd0;
                job.pat_n = '0;
                if (hit) begin
                    job.emit   = 1'b0;
                    phase_next = PH_SPACE;
                end
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PATTERN |-> int'(count_reg) < PATTERN_MAX)
        else $error("matched count out of range in pattern phase");
    a_emit_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && job.emit |=> phase_reg == PH_START)
        else $error("phase did not restart after an emitting byte");
`endif

endmodule

[hw/rtl/cms_replay.sv]
// Replay sequencer: walks one job byte by byte into the output register.
`timescale 1ns / 1ps

module cms_replay
    import cms_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  cms_job_t                job,
    input  logic [PAT_W-1:0]        pattern_bytes,
    output logic                    idle,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [BYTE_W-1:0]       m_tdata,
    output logic                    m_tlast
);

    cms_rp_state_t     state_reg, state_next;
    cms_job_t          job_reg, job_next;
    logic [POS_W-1:0]  k_reg, k_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic              last_reg, last_next;
    logic [POS_W:0]    total;
    logic [POS_W-1:0]  n_len;
    logic [POS_W-1:0]  j;
    logic [BYTE_W-1:0] cur_byte;
    logic              load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= RP_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        job_reg  <= job_next;
        k_reg    <= k_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    always_comb begin
        total = {3'b000, job_reg.head} + {2'b00, job_reg.pat_n} + {4'b0000, job_reg.close}
              + 5'd1;
        n_len = (total > 5'(MAX_RESULTS)) ? 4'(MAX_RESULTS) : total[POS_W-1:0];
        j     = k_reg - {2'b00, job_reg.head};
        if (k_reg == '0 && job_reg.head != 2'd0) begin
            cur_byte = CHR_SPACE;
        end else if (k_reg < {2'b00, job_reg.head}) begin
            cur_byte = CHR_OPEN;
        end else if (j < {1'b0, job_reg.pat_n}) begin
            cur_byte = pat_byte(pattern_bytes, j[LEN_W-1:0]);
        end else if (j == {1'b0, job_reg.pat_n} && job_reg.close) begin
            cur_byte = CHR_CLOSE;
        end else begin
            cur_byte = job_reg.data;
        end
    end

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        k_next     = k_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !m_tready;
        load       = 1'b0;
        case (state_reg)
            RP_IDLE: begin
                if (start && job.emit) begin
                    job_next   = job;
                    k_next     = '0;
                    state_next = RP_RUN;
                end
            end
            RP_RUN: begin
                if (!valid_reg || m_tready) begin
                    load       = 1'b1;
                    valid_next = 1'b1;
                    data_next  = cur_byte;
                    last_next  = (k_reg == n_len - 1'b1);
                    k_next     = k_reg + 1'b1;
                    if (k_reg == n_len - 1'b1) begin
                        state_next = RP_IDLE;
                    end
                end
            end
            default: begin
                state_next = RP_IDLE;
            end
        endcase
    end

    assign idle     = (state_reg == RP_IDLE);
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

`ifndef SYNTHESIS
    a_pos_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == RP_RUN |-> k_reg < n_len)
        else $error("replay position passed the end of the job");
    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        load && last_next |=> state_reg == RP_IDLE && valid_reg && last_reg)
        else $error("replay did not stop after the final beat");
`endif

endmodule

[hw/rtl/conditional_marker_stripper_top.sv]
// Top level of the conditional marker stripper with its configuration registers.
`timescale 1ns / 1ps

// The block removes markers made of a space, two open parentheses, the configured
// pattern and two close parentheses from a byte stream; a byte that breaks a partial
// match never opens a marker itself. Bytes arrive on the s_ channel and filtered bytes
// leave on the m_ channel; m_tlast marks the final output beat caused by one input beat.
// Bytes of a possible marker are held back and produce no beat; on a mismatch the held
// bytes are replayed, then the byte that broke the match, with a replay cut to at most
// eleven beats. An accepted input beat is stored as a job in the replay sequencer, which
// then writes its beats into the output register and keeps s_tready low until the last
// is written; a held byte leaves s_tready high. The sequencer writes one beat per cycle
// while the receiver takes them, and takes no new input while a replay is under way.
// When the receiver stalls, the waiting beat stays in the output register and the
// sequencer holds its position. Reset clears the match state and the output valid flag
// and sets the pattern to zero bytes with length one. The pattern registers are written
// through cfg_wr_en, cfg_index and cfg_wdata; the user must write them only while the
// block is idle, as the block itself does not enforce this.

module conditional_marker_stripper_top
    import cms_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [PAT_W-1:0]  cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] in_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] out_byte
    output logic              m_tlast
);

    logic [PAT_W-1:0] pattern_bytes_reg;
    logic [LEN_W-1:0] pattern_length_reg;
    logic             accept;
    logic             rp_idle;
    cms_job_t         job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= LEN_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PATTERN_BYTES:  pattern_bytes_reg  <= cfg_wdata;
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_wdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = rp_idle;
    assign accept   = s_tvalid && s_tready;

    cms_matcher u_matcher (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .in_byte        (s_tdata),
        .pattern_bytes  (pattern_bytes_reg),
        .pattern_length (pattern_length_reg),
        .job            (job)
    );

    cms_replay u_replay (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (accept),
        .job           (job),
        .pattern_bytes (pattern_bytes_reg),
        .idle          (rp_idle),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast)
    );

endmodule

[dv/cms_checker.sv]
// Checker that predicts the filtered byte stream of the marker stripper and compares it beat by beat.
`timescale 1ns / 1ps

module cms_checker
    import cms_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [PAT_W-1:0]  cfg_wdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] in_byte
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [7:0]        m_tdata,   // [7:0] out_byte
    input  logic              m_tlast,
    output int                fail_count,
    output int                pending,
    output int                beats_checked
);

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
    } out_beat_t;

    cms_phase_t        phase;
    logic [LEN_W-1:0]  matched;
    logic [PAT_W-1:0]  pat_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [BYTE_W-1:0] emit_q[$];
    out_beat_t         filtered_q[$];

    function automatic logic [BYTE_W-1:0] pattern_at(input int idx);
        return (idx < PATTERN_MAX) ? pat_reg[idx*BYTE_W +: BYTE_W] : '0;
    endfunction

    function automatic void hold_replay(input int n_pat);
        emit_q.push_back(CHR_SPACE);
        emit_q.push_back(CHR_OPEN);
        emit_q.push_back(CHR_OPEN);
        for (int i = 0; i < n_pat && i < PATTERN_MAX; i++) begin
            emit_q.push_back(pattern_at(i));
        end
    endfunction

    function automatic void strip_byte(input logic [BYTE_W-1:0] c);
        out_beat_t beat;
        int n;
        emit_q.delete();
        case (phase)
            PH_SPACE: begin
                if (c == CHR_OPEN) begin
                    phase = PH_OPEN1;
                end else begin
                    emit_q.push_back(CHR_SPACE);
                    emit_q.push_back(c);
                    phase = PH_START;
                end
            end
            PH_OPEN1: begin
                if (c == CHR_OPEN) begin
                    matched = '0;
                    phase = (len_reg == 0) ? PH_MATCHED : PH_PATTERN;
                end else begin
                    emit_q.push_back(CHR_SPACE);
                    emit_q.push_back(CHR_OPEN);
                    emit_q.push_back(c);
                    phase = PH_START;
                end
            end
            PH_PATTERN: begin
                if (matched < PATTERN_MAX && c == pattern_at(matched)) begin
                    matched = matched + 1'b1;
                    if (matched >= len_reg) begin
                        phase = PH_MATCHED;
                    end
                end else begin
                    hold_replay(matched);
                    emit_q.push_back(c);
                    phase = PH_START;
                end
            end
            PH_MATCHED: begin
                if (c == CHR_CLOSE) begin
                    phase = PH_CLOSE1;
                end else begin
                    hold_replay(len_reg);
                    emit_q.push_back(c);
                    phase = PH_START;
                end
            end
            PH_CLOSE1: begin
                if (c != CHR_CLOSE) begin
                    hold_replay(len_reg);
                    emit_q.push_back(CHR_CLOSE);
                    emit_q.push_back(c);
                end
                phase = PH_START;
            end
            default: begin
                if (c != CHR_SPACE) begin
                    emit_q.push_back(c);
                end
                phase = (c == CHR_SPACE) ? PH_SPACE : PH_START;
            end
        endcase
        // A replay longer than the output limit loses its tail, the offending byte included.
        n = (emit_q.size() > MAX_RESULTS) ? MAX_RESULTS : emit_q.size();
        for (int k = 0; k < n; k++) begin
            beat.out_byte = emit_q[k];
            beat.last_of_run = (k == n - 1);
            filtered_q.push_back(beat);
        end
    endfunction

    always @(posedge aclk) begin
        int bad;
        out_beat_t want;
        bad = 0;
        if (!aresetn) begin
            phase = PH_START;
            matched = '0;
            pat_reg = '0;
            len_reg = LEN_W'(1);
            filtered_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (filtered_q.size() == 0) begin
                    $error("out_byte: no beat expected, got %02h (last_of_run %0b)",
                           m_tdata, m_tlast);
                    bad++;
                end else begin
                    want = filtered_q.pop_front();
                    if (m_tdata !== want.out_byte) begin
                        $error("out_byte: expected %02h, got %02h", want.out_byte, m_tdata);
                        bad++;
                    end
                    if (m_tlast !== want.last_of_run) begin
                        $error("last_of_run: expected %0b, got %0b", want.last_of_run, m_tlast);
                        bad++;
                    end
                end
                beats_checked <= beats_checked + 1;
            end
            if (s_tvalid && s_tready) begin
                strip_byte(s_tdata);
            end
            if (cfg_wr_en) begin
                if (cfg_index == REG_PATTERN_BYTES) begin
                    pat_reg = cfg_wdata;
                end else begin
                    len_reg = cfg_wdata[LEN_W-1:0];
                end
            end
        end
        fail_count <= fail_count + bad;
        pending <= filtered_q.size();
    end

endmodule

[dv/tb_top.sv]
// Testbench top that drives byte streams and pattern settings into the marker stripper.
`timescale 1ns / 1ps

module tb_top;
    import cms_pkg::*;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic              cfg_index = REG_PATTERN_BYTES;
    logic [PAT_W-1:0]  cfg_wdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;
    logic              m_tlast;

    int fail_count;
    int pending;
    int beats_checked;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int bytes_sent = 0;
    int settings_used = 0;

    logic [PAT_W-1:0] cur_pat = '0;
    logic [LEN_W-1:0] cur_len = LEN_W'(1);

    conditional_marker_stripper_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    cms_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending       (pending),
        .beats_checked (beats_checked)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) begin
            send_byte(t[i]);
        end
    endtask

    function automatic logic [7:0] marker_at(input int k);
        if (k == 0) return CHR_SPACE;
        if (k < 3) return CHR_OPEN;
        if (k < 3 + cur_len) return cur_pat[(k-3)*8 +: 8];
        return CHR_CLOSE;
    endfunction

    task automatic send_marker(input int count);
        for (int k = 0; k < count; k++) begin
            send_byte(marker_at(k));
        end
    endtask

    function automatic logic [7:0] stray_byte();
        case ($urandom_range(5))
            0: return CHR_SPACE;
            1: return CHR_OPEN;
            2: return CHR_CLOSE;
            3: return cur_pat[$urandom_range(PATTERN_MAX-1)*8 +: 8];
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [PAT_W-1:0] pack_text(input string t);
        logic [PAT_W-1:0] p;
        p = '0;
        for (int i = 0; i < t.len() && i < PATTERN_MAX; i++) begin
            p[i*8 +: 8] = t[i];
        end
        return p;
    endfunction

    function automatic logic [PAT_W-1:0] random_pattern();
        logic [PAT_W-1:0] p;
        p = PAT_W'({$urandom, $urandom});
        // Half of the patterns use a tiny alphabet so that near misses are common.
        if ($urandom_range(1) == 1) begin
            for (int i = 0; i < PATTERN_MAX; i++) begin
                p[i*8 +: 8] = 8'h61 + 8'($urandom_range(3));
            end
        end
        return p;
    endfunction

    task automatic set_pattern(input logic [PAT_W-1:0] pat, input logic [LEN_W-1:0] len);
        logic [PAT_W-1:0] len_word;
        len_word = PAT_W'({$urandom, $urandom});
        len_word[LEN_W-1:0] = len;
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_PATTERN_BYTES;
        cfg_wdata <= pat;
        @(posedge aclk);
        cfg_index <= REG_PATTERN_LENGTH;
        cfg_wdata <= len_word;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_pat = pat;
        cur_len = len;
        settings_used++;
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    initial begin
        int goal;
        int r;
        logic [LEN_W-1:0] len;

        src_idle_pct = 21;
        sink_idle_pct = 62;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // After reset the pattern is a single zero byte.
        send_text(" ((");
        send_byte(8'h00);
        send_text("))");
        send_byte(8'hFF);
        wait_drain();

        // Empty pattern; the space after the first mismatch must not open a marker.
        set_pattern('0, LEN_W'(0));
        send_text(" ( (()) (())");
        wait_drain();

        // A failure after the first close paren overflows the replay.
        set_pattern(pack_text("abcdefg"), LEN_W'(7));
        send_text(" ((abcdefg)x");
        send_text(" ((a");
        wait_drain();

        // Shortening the pattern while a match is held lets the next byte complete it.
        set_pattern(pack_text("abcdefg"), LEN_W'(2));
        send_text("b))");
        wait_drain();

        for (int s = 0; s < 12; s++) begin
            src_idle_pct = (s < 4) ? 21 : (s < 8) ? 62 : 0;
            sink_idle_pct = (s < 4) ? 62 : (s < 8) ? 21 : 0;
            case (s % 4)
                0: len = LEN_W'(7);
                1: len = LEN_W'(0);
                default: len = LEN_W'($urandom_range(1, 7));
            endcase
            set_pattern(random_pattern(), len);
            goal = bytes_sent + 34;
            while (bytes_sent < goal) begin
                r = $urandom_range(99);
                if (r < 40) begin
                    send_marker(cur_len + 5);
                end else if (r < 75) begin
                    send_marker($urandom_range(1, cur_len + 4));
                    send_byte(stray_byte());
                end else begin
                    repeat ($urandom_range(1, 4)) send_byte(stray_byte());
                end
            end
            wait_drain();
        end

        $display("tb: %0d input beats under %0d pattern settings, %0d output beats checked",
                 bytes_sent, settings_used, beats_checked);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
